// ===== hdl/fnpa_pkg.sv =====
package fnpa_pkg;

  // Field widths of the block's items and registers.
  localparam int COORD_W   = 20;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 15;
  localparam int ENTRIES_W = 16;
  localparam int LIMIT_W   = 44;
  localparam int DIST_W    = 2 * COORD_W + 1;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 1'd1;

  // Reset value of the distance limit (an unsigned integer squared distance).
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 44'd25600000;

  // Operation codes of an input beat.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic signed [VAL_W-1:0] u;
    logic signed [VAL_W-1:0] v;
  } entry_t;

  // A scanned entry with its squared distance to the query point.
  typedef struct packed {
    logic                    valid;
    logic [DIST_W-1:0]       d;
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic signed [VAL_W-1:0] u;
    logic signed [VAL_W-1:0] v;
  } cand_t;

  // Control from the sequencer to the ranking unit.
  typedef struct packed {
    logic clear;
    logic sum_go;
  } rank_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SUM,
    ST_DONE
  } fnpa_state_t;

endpackage

// ===== hdl/fnpa_if.sv =====
interface fnpa_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [fnpa_pkg::IDX_W-1:0]       entry_index;
  logic [fnpa_pkg::COORD_W-1:0]     point_x;
  logic [fnpa_pkg::COORD_W-1:0]     point_y;
  logic signed [fnpa_pkg::VAL_W-1:0] value_u;
  logic signed [fnpa_pkg::VAL_W-1:0] value_v;

  modport source (
    output valid, func, entry_index, point_x, point_y, value_u, value_v,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, point_x, point_y, value_u, value_v,
    output ready
  );
endinterface

interface fnpa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fnpa_pkg::VAL_W-1:0] average_u;
  logic signed [fnpa_pkg::VAL_W-1:0] average_v;

  modport source (
    output valid, average_u, average_v,
    input  ready
  );
  modport sink (
    input  valid, average_u, average_v,
    output ready
  );
endinterface

// ===== hdl/fnpa_table.sv =====
module fnpa_table #(
  parameter int DEPTH = 32768
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  fnpa_pkg::entry_t           wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output fnpa_pkg::entry_t           rd_data
);
  import fnpa_pkg::*;

  entry_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/fnpa_dist.sv =====
module fnpa_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  fnpa_pkg::entry_t              entry,
  input  logic [fnpa_pkg::COORD_W-1:0]  qx,
  input  logic [fnpa_pkg::COORD_W-1:0]  qy,
  output fnpa_pkg::cand_t               cand,
  output logic                          busy
);
  import fnpa_pkg::*;

  logic                 v0, v1, v2;
  entry_t               e1, e2;
  logic [COORD_W-1:0]   dx, dy;
  logic [2*COORD_W-1:0] sqx, sqy;

  // Valid bits follow the memory read through the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v0 <= rd_en;
      v1 <= v0;
      v2 <= v1;
    end
  end

  // Stage one: absolute coordinate differences.
  always_ff @(posedge clk) begin
    dx <= (entry.x >= qx) ? entry.x - qx : qx - entry.x;
    dy <= (entry.y >= qy) ? entry.y - qy : qy - entry.y;
    e1 <= entry;
  end

  // Stage two: the two squares.
  always_ff @(posedge clk) begin
    sqx <= dx * dx;
    sqy <= dy * dy;
    e2  <= e1;
  end

  // The squared distance feeds the ranking unit directly.
  always_comb begin
    cand.valid = v2;
    cand.d     = DIST_W'(sqx) + DIST_W'(sqy);
    cand.x     = e2.x;
    cand.y     = e2.y;
    cand.u     = e2.u;
    cand.v     = e2.v;
  end

  assign busy = v0 | v1 | v2;

endmodule

// ===== hdl/fnpa_rank.sv =====
module fnpa_rank #(
  parameter int NEIGHBOURS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fnpa_pkg::rank_ctl_t               ctl,
  input  fnpa_pkg::cand_t                   cand,
  input  logic [fnpa_pkg::LIMIT_W-1:0]      limit,
  output logic                              sum_done,
  output logic signed [fnpa_pkg::VAL_W-1:0] avg_u,
  output logic signed [fnpa_pkg::VAL_W-1:0] avg_v
);
  import fnpa_pkg::*;

  localparam int CW = $clog2(NEIGHBOURS + 1);
  localparam int SW = VAL_W + $clog2(NEIGHBOURS) + 1;

  cand_t                  slots      [NEIGHBOURS];
  cand_t                  ins_next   [NEIGHBOURS];
  cand_t                  shift_next [NEIGHBOURS];
  cand_t                  cand_slot;
  logic [NEIGHBOURS-1:0]  lt, lt_prev;
  logic                   dup, in_limit, take;
  logic                   running;
  logic [CW-1:0]          cnt;
  logic signed [SW-1:0]   acc_u, acc_v;

  // Floor division by four, saturated to the 32-bit signed range.
  function automatic logic signed [VAL_W-1:0] sat_quarter(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] q;
    q = s >>> 2;
    if (q > $signed({{(SW-VAL_W){1'b0}}, 1'b0, {(VAL_W-1){1'b1}}})) begin
      sat_quarter = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (q < $signed({{(SW-VAL_W){1'b1}}, 1'b1, {(VAL_W-1){1'b0}}})) begin
      sat_quarter = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_quarter = q[VAL_W-1:0];
    end
  endfunction

  // Sorted insertion: slots stay ordered by distance, earlier index first
  // on ties. A point whose coordinates are already held is dropped.
  always_comb begin
    cand_slot       = cand;
    cand_slot.valid = 1'b1;
    dup             = 1'b0;
    for (int j = 0; j < NEIGHBOURS; j++) begin
      lt[j] = !slots[j].valid || (cand.d < slots[j].d);
      dup   = dup || (slots[j].valid && slots[j].x == cand.x && slots[j].y == cand.y);
    end
    lt_prev  = lt << 1;
    in_limit = LIMIT_W'(cand.d) < limit;
    take     = cand.valid && in_limit && !dup;
    ins_next[0] = (take && lt[0]) ? cand_slot : slots[0];
    for (int j = 1; j < NEIGHBOURS; j++) begin
      if (take && lt[j]) begin
        ins_next[j] = lt_prev[j] ? slots[j-1] : cand_slot;
      end else begin
        ins_next[j] = slots[j];
      end
    end
  end

  // While summing, the slots shift toward slot zero one per cycle.
  always_comb begin
    for (int j = 0; j < NEIGHBOURS - 1; j++) begin
      shift_next[j] = slots[j+1];
    end
    shift_next[NEIGHBOURS-1]       = slots[NEIGHBOURS-1];
    shift_next[NEIGHBOURS-1].valid = 1'b0;
  end

  // Slot registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int j = 0; j < NEIGHBOURS; j++) begin
        slots[j].valid <= 1'b0;
      end
    end else if (running) begin
      slots <= shift_next;
    end else begin
      slots <= ins_next;
    end
  end

  // Accumulate u and v over the slots, one slot per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      sum_done <= 1'b0;
    end else if (ctl.sum_go) begin
      running  <= 1'b1;
      sum_done <= 1'b0;
    end else if (running) begin
      if (cnt == CW'(1)) begin
        running  <= 1'b0;
        sum_done <= 1'b1;
      end
    end else begin
      sum_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_go) begin
      cnt   <= CW'(NEIGHBOURS);
      acc_u <= '0;
      acc_v <= '0;
    end else if (running) begin
      cnt   <= cnt - CW'(1);
      acc_u <= acc_u + (slots[0].valid ? SW'(slots[0].u) : SW'(0));
      acc_v <= acc_v + (slots[0].valid ? SW'(slots[0].v) : SW'(0));
    end
  end

  assign avg_u = sat_quarter(acc_u);
  assign avg_v = sat_quarter(acc_v);

endmodule

// ===== hdl/four_nearest_point_average_core.sv =====
// Load beat: accepted while idle, written to the table memory at once, no result.
// Query beat: the scan reads n entries, n being the clamped entry count; one table entry is
// read per cycle from the single read port of the table memory, and the next beat is taken
// only after the result has been loaded into the output register.
// Reset clears the sequencer, the output valid bit, the entry count (zero) and
// sets the distance limit to 25600000; table contents stay undefined until loaded.
module four_nearest_point_average_core #(
  parameter int TABLE_DEPTH = 32768,
  parameter int NEIGHBOURS  = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  fnpa_in_if.sink                           req,
  fnpa_out_if.source                        rsp,
  input  logic                              cfg_we,
  input  logic [fnpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fnpa_pkg::LIMIT_W-1:0]      cfg_data
);
  import fnpa_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W = (CNT_W > ENTRIES_W) ? CNT_W : ENTRIES_W;
  localparam int XW    = (AW > IDX_W) ? AW : IDX_W;

  fnpa_state_t             state, state_next;
  logic [ENTRIES_W-1:0]    entries_in_use;
  logic [LIMIT_W-1:0]      max_distance_squared;
  logic [CNT_W-1:0]        n_reg, scan_cnt;
  logic [LIM_W-1:0]        n_ext, n_clamp;
  logic [XW-1:0]           idx_ext;
  logic [COORD_W-1:0]      qx, qy;
  logic                    accept, is_query, last_scan;
  logic                    tbl_we, rd_en, load_out, dist_busy, sum_done;
  entry_t                  wr_data, rd_data;
  cand_t                   cand;
  rank_ctl_t               rank_ctl;
  logic signed [VAL_W-1:0] avg_u, avg_v;

  assign accept    = req.valid && req.ready;
  assign is_query  = req.func == FUNC_QUERY;
  assign idx_ext   = XW'(req.entry_index);
  assign n_ext     = LIM_W'(entries_in_use);
  assign n_clamp   = (n_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : n_ext;
  assign last_scan = (scan_cnt + CNT_W'(1)) == n_reg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use       <= '0;
      max_distance_squared <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRIES: entries_in_use       <= cfg_data[ENTRIES_W-1:0];
        REG_LIMIT:   max_distance_squared <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_next = (n_clamp == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_scan) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!dist_busy) state_next = ST_SUM;
      end
      ST_SUM: begin
        if (sum_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req.ready       = state == ST_IDLE;
    tbl_we          = 1'b0;
    rd_en           = 1'b0;
    load_out        = 1'b0;
    rank_ctl.clear  = 1'b0;
    rank_ctl.sum_go = 1'b0;
    unique case (state)
      ST_IDLE: begin
        tbl_we         = accept && !is_query && (32'(idx_ext) < 32'(TABLE_DEPTH));
        rank_ctl.clear = accept && is_query;
      end
      ST_SCAN:  rd_en           = 1'b1;
      ST_DRAIN: rank_ctl.sum_go = !dist_busy;
      ST_SUM:   ;
      ST_DONE:  load_out        = !rsp.valid || rsp.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Query point, entry count and scan address.
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      qx       <= req.point_x;
      qy       <= req.point_y;
      n_reg    <= n_clamp[CNT_W-1:0];
      scan_cnt <= '0;
    end else if (rd_en) begin
      scan_cnt <= scan_cnt + CNT_W'(1);
    end
  end

  always_comb begin
    wr_data.x = req.point_x;
    wr_data.y = req.point_y;
    wr_data.u = req.value_u;
    wr_data.v = req.value_v;
  end

  fnpa_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  fnpa_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .rd_en (rd_en),
    .entry (rd_data),
    .qx    (qx),
    .qy    (qy),
    .cand  (cand),
    .busy  (dist_busy)
  );

  fnpa_rank #(.NEIGHBOURS(NEIGHBOURS)) u_rank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rank_ctl),
    .cand     (cand),
    .limit    (max_distance_squared),
    .sum_done (sum_done),
    .avg_u    (avg_u),
    .avg_v    (avg_v)
  );

  // Output register: holds the result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.average_u <= avg_u;
      rsp.average_v <= avg_v;
    end
  end

`ifndef SYNTH
  // A result beat only appears after the sum has finished.
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_DONE)
    else $error("result beat without a finished query");

  // The table is only written from idle.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> state == ST_IDLE)
    else $error("table write outside idle");

  // The scan never reads beyond the entry count.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> scan_cnt < n_reg)
    else $error("scan address beyond entry count");

  // Summing starts only once the distance pipeline is empty.
  a_sum_drained: assert property (@(posedge clk) disable iff (rst)
    rank_ctl.sum_go |-> !dist_busy && !cand.valid)
    else $error("sum started with candidates in flight");
`endif

endmodule

// ===== tb/four_nearest_point_average_core_tb.sv =====
`timescale 1ns / 1ps

module four_nearest_point_average_core_tb;
  import fnpa_pkg::*;

  localparam int TABLE_DEPTH   = 32768;
  localparam int NEIGHBOURS    = 4;
  localparam int SETTLE_CYCLES = NEIGHBOURS + 8;
  localparam int PHASE_ITEMS   = 20;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

  // One expected answer of a query.
  typedef struct packed {
    logic signed [VAL_W-1:0] u;
    logic signed [VAL_W-1:0] v;
  } average_pair_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_data;

  fnpa_in_if  req_if ();
  fnpa_out_if rsp_if ();

  four_nearest_point_average_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NEIGHBOURS (NEIGHBOURS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Mirror of the sample table and of the two registers.
  entry_t               sample_mem [TABLE_DEPTH];
  bit                   loaded [TABLE_DEPTH];
  int                   loaded_prefix = 0;
  logic [ENTRIES_W-1:0] entries_in_use_q = '0;
  logic [LIMIT_W-1:0]   distance_limit_q = LIMIT_RESET;
  average_pair_t        pending_averages [$];

  int src_idle_pct     = 0;
  int rcv_stall_pct    = 0;
  int mismatch_count   = 0;
  int loads_sent       = 0;
  int queries_sent     = 0;
  int averages_checked = 0;

  logic [COORD_W-1:0] cluster_x = '0;
  logic [COORD_W-1:0] cluster_y = '0;
  int                 cluster_span = 16;

  always #5 clk = ~clk;

  // Squared distance along one axis.
  function automatic logic [DIST_W-1:0] axis_sq(input logic [COORD_W-1:0] a, b);
    logic [COORD_W-1:0] diff;
    diff = (a > b) ? a - b : b - a;
    return DIST_W'(diff) * DIST_W'(diff);
  endfunction

  // Average of u and v over the nearest table points to (qx, qy). Each round
  // takes the first strictly closer point below the limit, skipping points
  // whose coordinates match one already taken.
  function automatic average_pair_t nearest_average(input logic [COORD_W-1:0] qx, qy);
    logic [COORD_W-1:0] taken_x [NEIGHBOURS];
    logic [COORD_W-1:0] taken_y [NEIGHBOURS];
    logic [LIMIT_W-1:0] best;
    logic [DIST_W-1:0]  sq_dist;
    longint             sum_u;
    longint             sum_v;
    longint             quot_u;
    longint             quot_v;
    int                 scan_len;
    int                 taken;
    int                 pick;
    int                 r;
    int                 i;
    int                 j;
    bit                 found;
    bit                 skip;
    bit                 exhausted;
    average_pair_t      res;
    scan_len  = (entries_in_use_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_in_use_q);
    taken     = 0;
    sum_u     = 0;
    sum_v     = 0;
    exhausted = 1'b0;
    for (r = 0; r < NEIGHBOURS && !exhausted; r++) begin
      best  = distance_limit_q;
      found = 1'b0;
      pick  = 0;
      for (i = 0; i < scan_len; i++) begin
        skip = 1'b0;
        for (j = 0; j < taken; j++) begin
          if (sample_mem[i].x == taken_x[j] && sample_mem[i].y == taken_y[j]) skip = 1'b1;
        end
        if (!skip) begin
          sq_dist = axis_sq(sample_mem[i].x, qx) + axis_sq(sample_mem[i].y, qy);
          if (LIMIT_W'(sq_dist) < best) begin
            best  = LIMIT_W'(sq_dist);
            pick  = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        taken_x[taken] = sample_mem[pick].x;
        taken_y[taken] = sample_mem[pick].y;
        taken++;
        sum_u += longint'(sample_mem[pick].u);
        sum_v += longint'(sample_mem[pick].v);
      end else begin
        exhausted = 1'b1;
      end
    end
    // Arithmetic shift rounds toward minus infinity.
    quot_u = sum_u >>> 2;
    quot_v = sum_v >>> 2;
    res.u  = quot_u[VAL_W-1:0];
    res.v  = quot_v[VAL_W-1:0];
    return res;
  endfunction

  function automatic void compare_field(input string name,
                                        input logic signed [VAL_W-1:0] got, want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Result side: check each accepted beat and stall at random.
  always @(posedge clk) begin
    average_pair_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_averages.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: average with no query waiting: u=%0d v=%0d",
                     $time, rsp_if.average_u, rsp_if.average_v);
        end else begin
          want = pending_averages.pop_front();
          averages_checked++;
          compare_field("average_u", rsp_if.average_u, want.u);
          compare_field("average_v", rsp_if.average_v, want.v);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Send one beat, with random idle cycles ahead of it, and update the
  // mirror when it is accepted.
  task automatic send_beat(input logic func, input logic [IDX_W-1:0] idx,
                           input logic [COORD_W-1:0] px, py,
                           input logic signed [VAL_W-1:0] u, v);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= func;
    req_if.entry_index <= idx;
    req_if.point_x     <= px;
    req_if.point_y     <= py;
    req_if.value_u     <= u;
    req_if.value_v     <= v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (func == FUNC_LOAD) begin
      sample_mem[idx] = '{px, py, u, v};
      loaded[idx] = 1'b1;
      while (loaded_prefix < TABLE_DEPTH && loaded[loaded_prefix]) loaded_prefix++;
      loads_sent++;
    end else begin
      pending_averages.push_back(nearest_average(px, py));
      queries_sent++;
    end
  endtask

  task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] px, py,
                            input logic signed [VAL_W-1:0] u, v);
    send_beat(FUNC_LOAD, idx, px, py, u, v);
  endtask

  // The unused fields of a query still carry random bits.
  task automatic query_point(input logic [COORD_W-1:0] px, py);
    send_beat(FUNC_QUERY, IDX_W'($urandom), px, py, $urandom, $urandom);
  endtask

  // Wait until every answer is in and the block has settled.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers once the block is idle.
  task automatic program_regs(input logic [ENTRIES_W-1:0] count,
                              input logic [LIMIT_W-1:0] limit);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENTRIES;
    cfg_data  <= LIMIT_W'(count);
    @(posedge clk);
    cfg_index <= REG_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    entries_in_use_q = count;
    distance_limit_q = limit;
    @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] near_cluster(input logic [COORD_W-1:0] c);
    int pos;
    pos = int'(c) + int'($urandom_range(2 * cluster_span)) - cluster_span;
    if (pos < 0) pos = 0;
    if (pos > int'(COORD_MAX)) pos = int'(COORD_MAX);
    return COORD_W'(pos);
  endfunction

  // Mostly points around the current cluster, some exact copies of loaded
  // coordinates, and a few anywhere in the plane.
  task automatic pick_point(output logic [COORD_W-1:0] px, py);
    int sel;
    int src;
    sel = $urandom_range(99);
    if (sel < 10) begin
      px = COORD_W'($urandom);
      py = COORD_W'($urandom);
    end else if (sel < 25 && loaded_prefix > 0) begin
      src = $urandom_range(loaded_prefix - 1);
      px  = sample_mem[src].x;
      py  = sample_mem[src].y;
    end else begin
      px = near_cluster(cluster_x);
      py = near_cluster(cluster_y);
    end
  endtask

  // Clusters now and then sit in a corner so that the offsets clamp.
  task automatic new_cluster();
    int sel;
    sel = $urandom_range(9);
    cluster_x    = (sel == 0) ? '0 : (sel == 1) ? COORD_MAX : COORD_W'($urandom);
    cluster_y    = (sel == 0) ? '0 : (sel == 1) ? COORD_MAX : COORD_W'($urandom);
    cluster_span = (sel < 4) ? 16 : (sel < 7) ? 256 : 4095;
  endtask

  function automatic logic [LIMIT_W-1:0] random_limit();
    case ($urandom_range(3))
      0:       return LIMIT_RESET;
      1:       return LIMIT_MAX;
      2:       return LIMIT_W'({$urandom, $urandom}) >> $urandom_range(LIMIT_W - 1);
      default: return LIMIT_W'($urandom_range(4000000));
    endcase
  endfunction

  // A random load or query; loads mostly touch the loaded prefix or extend it.
  task automatic random_beat();
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [IDX_W-1:0]   idx;
    int                 sel;
    pick_point(px, py);
    if ($urandom_range(99) < 40) begin
      query_point(px, py);
    end else begin
      sel = $urandom_range(99);
      if (sel < 20)
        idx = IDX_W'($urandom);
      else if (sel < 60)
        idx = IDX_W'($urandom_range(loaded_prefix - 1));
      else
        idx = IDX_W'((loaded_prefix < TABLE_DEPTH) ? loaded_prefix : TABLE_DEPTH - 1);
      load_entry(idx, px, py, $urandom, $urandom);
    end
  endtask

  // A query on an empty table answers zero.
  task automatic test_empty_table();
    query_point(20'd100, 20'd200);
  endtask

  // Extreme coordinates and values, duplicate coordinates, equal distances,
  // and the top slot of the table.
  task automatic test_edge_loads();
    load_entry(15'd0, '0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    load_entry(15'd1, COORD_MAX, COORD_MAX, -32'sd1, 32'sd1);
    load_entry(15'd2, '0, '0, 32'sd5, -32'sd5);
    load_entry(15'd3, 20'd16, '0, -32'sd1, -32'sd1);
    load_entry(15'd4, '0, 20'd16, -32'sd3, 32'sd7);
    load_entry(15'd5, COORD_MAX, '0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    load_entry(15'h7FFF, 20'hAAAAA, 20'h55555, 32'sh5555_5555, 32'shAAAA_AAAA);
  endtask

  // All entries within reach: index order on ties, duplicates skipped,
  // negative sums rounded down.
  task automatic test_nearest_selection();
    program_regs(16'd6, LIMIT_MAX);
    query_point('0, '0);
    query_point(COORD_MAX, COORD_MAX);
    query_point(20'd8, 20'd8);
    query_point(20'h7FFFF, 20'h80000);
  endtask

  // A zero limit, a limit that leaves later rounds empty, the reset limit,
  // and a zero entry count with the widest limit.
  task automatic test_distance_limit();
    program_regs(16'd6, '0);
    query_point('0, '0);
    program_regs(16'd6, 44'd257);
    query_point('0, '0);
    program_regs(16'd6, LIMIT_RESET);
    query_point(20'd10, 20'd10);
    program_regs(16'd0, LIMIT_MAX);
    query_point(COORD_MAX, '0);
  endtask

  // Random loads and queries under one idle and stall mix, two settings each.
  task automatic test_random_mix(input int src_pct, input int rcv_pct);
    src_idle_pct  = src_pct;
    rcv_stall_pct = rcv_pct;
    new_cluster();
    repeat (2) begin
      program_regs(ENTRIES_W'($urandom_range((loaded_prefix < 64) ? loaded_prefix : 64, 1)),
                   random_limit());
      repeat (PHASE_ITEMS / 2) random_beat();
    end
  endtask

  // Scan every contiguously loaded entry, with the widest and the reset limit.
  task automatic test_long_scan();
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    src_idle_pct  = 0;
    rcv_stall_pct = 20;
    new_cluster();
    program_regs(ENTRIES_W'(loaded_prefix), LIMIT_MAX);
    repeat (2) begin
      pick_point(px, py);
      query_point(px, py);
    end
    program_regs(ENTRIES_W'(loaded_prefix), LIMIT_RESET);
    repeat (2) begin
      pick_point(px, py);
      query_point(px, py);
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_ENTRIES;
    cfg_data           = '0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_LOAD;
    req_if.entry_index = '0;
    req_if.point_x     = '0;
    req_if.point_y     = '0;
    req_if.value_u     = '0;
    req_if.value_v     = '0;
    rsp_if.ready       = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_edge_loads();
    test_nearest_selection();
    test_distance_limit();
    test_random_mix(0, 0);
    test_random_mix(51, 0);
    test_random_mix(0, 51);
    test_random_mix(20, 20);
    test_long_scan();

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d table loads and %0d queries, checked %0d averages, %0d mismatches.",
             loads_sent, queries_sent, averages_checked, mismatch_count);
    $display("Covered empty and partial rounds, ties, duplicates, four idle mixes, long scans.");
    if (mismatch_count == 0 && pending_averages.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d averages still outstanding.", pending_averages.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
